@@ rtl/slrg_pkg.sv @@
// slrg_pkg: constants, state type and modular helper for the subtractive
// lagged random generator. No dependencies.

package slrg_pkg;

    localparam int TABLE_LEN = 55;
    localparam int IDX_W     = 6;
    localparam int WORD_W    = 30;

    localparam logic [WORD_W-1:0] MODULUS     = 30'd1000000000;
    localparam logic [30:0]       SEED_BASE   = 31'd161803398;
    localparam logic [IDX_W-1:0]  STRIDE      = 6'd21;
    localparam logic [IDX_W-1:0]  LAST_IDX    = 6'd54;
    localparam logic [IDX_W-1:0]  TRAIL_START = 6'd31;
    localparam logic [IDX_W-1:0]  MIX_OFFSET  = 6'd31;
    localparam logic [IDX_W-1:0]  FILL_STEPS  = 6'd54;
    localparam logic [IDX_W-1:0]  TABLE_TOP   = 6'd55;
    localparam logic [1:0]        LAST_PASS   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_DIST,
        ST_SEED_START,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_DRAW_RD,
        ST_DRAW_WR
    } t_state;

    // (a - b) mod 1e9 for a, b below 1e9
    function automatic logic [WORD_W-1:0] sub_mod(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] diff;
        logic [WORD_W:0] wrapped;
        diff    = {1'b0, a} - {1'b0, b};
        wrapped = diff + {1'b0, MODULUS};
        return diff[WORD_W] ? wrapped[WORD_W-1:0] : diff[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/slrg_ram.sv @@
// slrg_ram: generic RAM, one write port and two registered read ports.
// No dependencies.

module slrg_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 55
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/subtractive_lagged_random_generator.sv @@
// subtractive_lagged_random_generator: top level, control sequencer and datapath.
// Depends on slrg_pkg and slrg_ram.
//
// Usage: each input item carries a signed 32-bit seed on i_seed with
// i_valid / o_ready; each result item gives o_value (1..999999999, the
// fraction is o_value * 1e-9) and o_reseeded on o_valid / i_ready.
// The 55-word state table sits in a RAM with two registered read ports.
// A draw reads the lead and trail words in ST_DRAW_RD and writes the
// difference back in ST_DRAW_WR; a draw that yields zero is repeated.
// Without reseeding a result is registered in ST_DRAW_WR, and the next item
// is taken once the sequencer is back in ST_IDLE. A negative seed, or the
// first item after reset, reseeds first: seed arithmetic, 55 fill writes
// and 4 mixing passes of 55 read-modify-write steps.
// Reset clears the control state and the seeded flag; table contents are
// left as they are and rebuilt by the first reseed.
// If the receiver stalls, the result waits in the output register; the next
// item is still accepted and runs up to its final write, where it holds
// until the output register is free.

module subtractive_lagged_random_generator
    import slrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [31:0] i_seed,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_value,
    output logic              o_reseeded
);

    t_state             r_state, n_state;
    logic               r_seeded, n_seeded;
    logic [IDX_W-1:0]   r_lead, n_lead;
    logic [IDX_W-1:0]   r_trail, n_trail;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]   r_other, n_other;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_pass, n_pass;
    logic               r_resd, n_resd;
    logic [30:0]        r_mag, n_mag;
    logic [30:0]        r_dist, n_dist;
    logic [WORD_W-1:0]  r_cur, n_cur;
    logic [WORD_W-1:0]  r_nxt, n_nxt;
    logic               r_ovalid, n_ovalid;
    logic [WORD_W-1:0]  r_ovalue, n_ovalue;
    logic               r_oresd, n_oresd;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]   ram_raddr_a;
    logic [IDX_W-1:0]   ram_raddr_b;
    logic [WORD_W-1:0]  ram_rdata_a;
    logic [WORD_W-1:0]  ram_rdata_b;

    logic [31:0]        seed_neg;
    logic [31:0]        seed_abs;
    logic [IDX_W-1:0]   lead_inc;
    logic [IDX_W-1:0]   trail_inc;
    logic [IDX_W:0]     pos_sum;
    logic [WORD_W-1:0]  diff;
    logic               out_free;

    slrg_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_LEN)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_ovalid;
    assign o_value    = r_ovalue;
    assign o_reseeded = r_oresd;

    assign seed_neg  = ~i_seed + 32'd1;
    assign seed_abs  = i_seed[31] ? seed_neg : i_seed;
    assign lead_inc  = (r_lead >= TABLE_TOP) ? 6'd1 : r_lead + 6'd1;
    assign trail_inc = (r_trail >= TABLE_TOP) ? 6'd1 : r_trail + 6'd1;
    assign pos_sum   = {1'b0, r_addr} + {1'b0, STRIDE};
    assign diff      = sub_mod(ram_rdata_a, ram_rdata_b);
    assign out_free  = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seeded <= 1'b0;
            r_lead   <= '0;
            r_trail  <= TRAIL_START;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_lead   <= n_lead;
            r_trail  <= n_trail;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_other  <= n_other;
        r_cnt    <= n_cnt;
        r_pass   <= n_pass;
        r_resd   <= n_resd;
        r_mag    <= n_mag;
        r_dist   <= n_dist;
        r_cur    <= n_cur;
        r_nxt    <= n_nxt;
        r_ovalue <= n_ovalue;
        r_oresd  <= n_oresd;
    end

    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_lead      = r_lead;
        n_trail     = r_trail;
        n_addr      = r_addr;
        n_other     = r_other;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_resd      = r_resd;
        n_mag       = r_mag;
        n_dist      = r_dist;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_ovalue    = r_ovalue;
        n_oresd     = r_oresd;
        n_ovalid    = r_ovalid && !i_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = r_nxt;
        ram_raddr_a = r_addr;
        ram_raddr_b = r_other;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mag   = seed_abs[31] ? 31'h7FFF_FFFF : seed_abs[30:0];
                    n_resd  = i_seed[31] || !r_seeded;
                    n_state = (i_seed[31] || !r_seeded) ? ST_SEED_DIST : ST_DRAW_RD;
                end
            end
            ST_SEED_DIST: begin
                n_dist  = (r_mag >= SEED_BASE) ? r_mag - SEED_BASE : SEED_BASE - r_mag;
                n_state = ST_SEED_START;
            end
            ST_SEED_START: begin
                // distance stays below twice the modulus
                ram_we    = 1'b1;
                ram_waddr = LAST_IDX;
                ram_wdata = (r_dist >= {1'b0, MODULUS}) ?
                            WORD_W'(r_dist - {1'b0, MODULUS}) : r_dist[WORD_W-1:0];
                n_cur     = ram_wdata;
                n_nxt     = WORD_W'(1);
                n_addr    = STRIDE;
                n_cnt     = 6'd1;
                n_state   = ST_FILL;
            end
            ST_FILL: begin
                // r_addr holds the 1-based spread position
                ram_we    = 1'b1;
                ram_waddr = r_addr - 6'd1;
                ram_wdata = r_nxt;
                n_nxt     = sub_mod(r_cur, r_nxt);
                n_cur     = r_nxt;
                n_addr    = (pos_sum >= {1'b0, TABLE_TOP}) ?
                            IDX_W'(pos_sum - {1'b0, TABLE_TOP}) : pos_sum[IDX_W-1:0];
                n_cnt     = r_cnt + 6'd1;
                if (r_cnt == FILL_STEPS) begin
                    n_addr  = '0;
                    n_other = MIX_OFFSET;
                    n_pass  = '0;
                    n_state = ST_MIX_RD;
                end
            end
            ST_MIX_RD: begin
                n_state = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = diff;
                n_addr    = (r_addr == LAST_IDX) ? '0 : r_addr + 6'd1;
                n_other   = (r_other == LAST_IDX) ? '0 : r_other + 6'd1;
                n_state   = ST_MIX_RD;
                if (r_addr == LAST_IDX) begin
                    n_pass = r_pass + 2'd1;
                    if (r_pass == LAST_PASS) begin
                        n_lead   = '0;
                        n_trail  = TRAIL_START;
                        n_seeded = 1'b1;
                        n_state  = ST_DRAW_RD;
                    end
                end
            end
            ST_DRAW_RD: begin
                ram_raddr_a = lead_inc - 6'd1;
                ram_raddr_b = trail_inc - 6'd1;
                n_lead      = lead_inc;
                n_trail     = trail_inc;
                n_state     = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                // addresses held so the read data stays put while stalled
                ram_raddr_a = r_lead - 6'd1;
                ram_raddr_b = r_trail - 6'd1;
                if (out_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lead - 6'd1;
                    ram_wdata = diff;
                    if (diff != '0) begin
                        n_ovalid = 1'b1;
                        n_ovalue = diff;
                        n_oresd  = r_resd;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state  = ST_DRAW_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value != '0) && (o_value < MODULUS))
        else $error("result value out of range");

    a_lag_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lead} + 7'd31 == {1'b0, r_trail}) ||
        ({1'b0, r_lead} + 7'd31 == {1'b0, r_trail} + 7'd55))
        else $error("lead and trail indexes lost their lag");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_DRAW_WR)
        else $error("result appeared outside the draw write step");

    a_draw_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW_RD) |-> r_seeded)
        else $error("draw started on an unseeded table");

endmodule
